FILE: sv/lsrc_pkg.sv
`default_nettype none

package lsrc_pkg;

    // Default coordinate width (signed fixed point, Q16.16 at 32 bits)
    localparam int LSRC_COORD_WIDTH = 32;

    // Width of the kept quotient magnitude
    localparam int LSRC_QUOT_WIDTH = 62;

    // Configuration register indexes
    typedef logic [1:0] lsrc_cfg_addr_t;

    localparam lsrc_cfg_addr_t CFG_MIN_X = 2'd0;
    localparam lsrc_cfg_addr_t CFG_MIN_Y = 2'd1;
    localparam lsrc_cfg_addr_t CFG_MAX_X = 2'd2;
    localparam lsrc_cfg_addr_t CFG_MAX_Y = 2'd3;

endpackage

`default_nettype wire

FILE: sv/lsrc_seg_if.sv
`default_nettype none

interface lsrc_seg_if
    import lsrc_pkg::*;
#(
    parameter int COORD_WIDTH = LSRC_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

FILE: sv/lsrc_res_if.sv
`default_nettype none

interface lsrc_res_if
    import lsrc_pkg::*;
#(
    parameter int COORD_WIDTH = LSRC_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          visible;
    logic signed [COORD_WIDTH-1:0] clip_start_x;
    logic signed [COORD_WIDTH-1:0] clip_start_y;
    logic signed [COORD_WIDTH-1:0] clip_end_x;
    logic signed [COORD_WIDTH-1:0] clip_end_y;

    modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                    input ready);
    modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/line_segment_rect_clip_unit.sv
// Line segment clipper against a rectangle held in four configuration registers.
// Channels: seg (sink) takes one segment per transfer, res (source) gives one
// result per segment: a visible flag and the clipped endpoints, or the input
// endpoints with visible low when the segment is rejected.
// Configuration: cfg_we/cfg_addr/cfg_data write clip_min_x, clip_min_y,
// clip_max_x, clip_max_y (indexes 0..3); write only while no segment is in flight.
// Throughput: one segment per cycle while res is not stalled. The pipeline holds
// the input register, the operand stage, two multiply stages, the four parallel
// restoring dividers, which resolve two quotient bits per stage over a
// 2*COORD_WIDTH+2 bit dividend (COORD_WIDTH+1 stages), and three stages of cut
// selection and output.
// The whole pipeline advances together: when res is stalled with a result
// held, seg.ready drops and every stage holds; nothing is lost or repeated.
// Reset clears all valid bits and sets the rectangle registers to zero.
`default_nettype none

module line_segment_rect_clip_unit
    import lsrc_pkg::*;
#(
    parameter int COORD_WIDTH = LSRC_COORD_WIDTH
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire lsrc_cfg_addr_t         cfg_addr,
    input  wire logic [COORD_WIDTH-1:0] cfg_data,
    lsrc_seg_if.sink                    seg,
    lsrc_res_if.source                  res
);
    localparam int W     = COORD_WIDTH;
    localparam int PW    = 2 * W + 2;
    localparam int STEPS = 2;
    localparam int NDIV  = PW / STEPS;
    localparam int LH    = (W + 1) / 2;
    localparam int HH    = W + 1 - LH;
    localparam int RW    = LSRC_QUOT_WIDTH;

    // Configuration registers
    logic signed [W-1:0] min_x_reg, min_y_reg, max_x_reg, max_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN_X: min_x_reg <= cfg_data;
                CFG_MIN_Y: min_y_reg <= cfg_data;
                CFG_MAX_X: max_x_reg <= cfg_data;
                CFG_MAX_Y: max_y_reg <= cfg_data;
            endcase
        end
    end

    // Global advance: move when the output slot is free or being taken
    logic o_valid_reg;
    logic adv;

    assign adv       = !o_valid_reg || res.ready;
    assign seg.ready = adv;

    // Stage A: input register
    logic                a_valid_reg;
    logic signed [W-1:0] a_p_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= seg.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_p_reg[0] <= seg.start_x;
            a_p_reg[1] <= seg.start_y;
            a_p_reg[2] <= seg.end_x;
            a_p_reg[3] <= seg.end_y;
        end
    end

    // Stage B: differences, magnitudes, signs, trivial accept and reject
    logic                b_valid_reg;
    logic signed [W-1:0] b_p_reg [4];
    logic                b_inside_reg, b_reject_reg;
    logic        [W:0]   b_ma_reg [4];
    logic        [W:0]   b_mb_reg [4];
    logic        [W:0]   b_md_reg [4];
    logic        [3:0]   b_neg_reg;

    logic        [W:0]   b_ma_next [4];
    logic        [W:0]   b_mb_next [4];
    logic        [W:0]   b_md_next [4];
    logic        [3:0]   b_neg_next;
    logic                b_inside_next, b_reject_next;

    always_comb
    begin
        logic signed [W:0]   dx, dy;
        logic signed [W:0]   na [4];
        logic signed [W:0]   nb [4];
        logic signed [W:0]   nd [4];
        logic signed [W-1:0] bx0, bx1, by0, by1;
        logic                wpos, hpos;

        dx = (W+1)'(a_p_reg[2]) - (W+1)'(a_p_reg[0]);
        dy = (W+1)'(a_p_reg[3]) - (W+1)'(a_p_reg[1]);
        na[0] = (W+1)'(min_y_reg) - (W+1)'(a_p_reg[1]);
        na[1] = (W+1)'(max_y_reg) - (W+1)'(a_p_reg[1]);
        na[2] = (W+1)'(min_x_reg) - (W+1)'(a_p_reg[0]);
        na[3] = (W+1)'(max_x_reg) - (W+1)'(a_p_reg[0]);
        nb[0] = dx;
        nb[1] = dx;
        nb[2] = dy;
        nb[3] = dy;
        nd[0] = dy;
        nd[1] = dy;
        nd[2] = dx;
        nd[3] = dx;
        for (int u = 0; u < 4; u++)
        begin
            b_ma_next[u]  = na[u][W] ? (W+1)'(-na[u]) : na[u];
            b_mb_next[u]  = nb[u][W] ? (W+1)'(-nb[u]) : nb[u];
            b_md_next[u]  = nd[u][W] ? (W+1)'(-nd[u]) : nd[u];
            b_neg_next[u] = na[u][W] ^ nb[u][W] ^ nd[u][W];
        end

        bx0  = (a_p_reg[0] < a_p_reg[2]) ? a_p_reg[0] : a_p_reg[2];
        bx1  = (a_p_reg[0] < a_p_reg[2]) ? a_p_reg[2] : a_p_reg[0];
        by0  = (a_p_reg[1] < a_p_reg[3]) ? a_p_reg[1] : a_p_reg[3];
        by1  = (a_p_reg[1] < a_p_reg[3]) ? a_p_reg[3] : a_p_reg[1];
        wpos = (bx1 != bx0);
        hpos = (by1 != by0);

        b_inside_next = (min_x_reg <= bx0) && (bx1 <= max_x_reg) &&
                        (min_y_reg <= by0) && (by1 <= max_y_reg);
        // Touching an edge rejects only a segment with extent in that axis
        b_reject_next = (bx1 < min_x_reg) || ((bx1 == min_x_reg) && wpos) ||
                        (max_x_reg < bx0) || ((max_x_reg == bx0) && wpos) ||
                        (by1 < min_y_reg) || ((by1 == min_y_reg) && hpos) ||
                        (max_y_reg < by0) || ((max_y_reg == by0) && hpos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_p_reg      <= a_p_reg;
            b_inside_reg <= b_inside_next;
            b_reject_reg <= b_reject_next;
            b_ma_reg     <= b_ma_next;
            b_mb_reg     <= b_mb_next;
            b_md_reg     <= b_md_next;
            b_neg_reg    <= b_neg_next;
        end
    end

    // Stage C: partial products of the numerator magnitudes
    logic                c_valid_reg;
    logic signed [W-1:0] c_p_reg [4];
    logic                c_inside_reg, c_reject_reg;
    logic        [W:0]   c_md_reg [4];
    logic        [3:0]   c_neg_reg;
    logic [W+LH:0]       c_pl_reg [4];
    logic [W+HH:0]       c_ph_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_p_reg      <= b_p_reg;
            c_inside_reg <= b_inside_reg;
            c_reject_reg <= b_reject_reg;
            c_md_reg     <= b_md_reg;
            c_neg_reg    <= b_neg_reg;
            for (int u = 0; u < 4; u++)
            begin
                c_pl_reg[u] <= b_ma_reg[u] * b_mb_reg[u][LH-1:0];
                c_ph_reg[u] <= b_ma_reg[u] * b_mb_reg[u][W:LH];
            end
        end
    end

    // Divider chain: index 0 holds the full product, each stage resolves STEPS bits
    logic                dv_valid_reg  [NDIV+1];
    logic                dv_inside_reg [NDIV+1];
    logic                dv_reject_reg [NDIV+1];
    logic [3:0]          dv_neg_reg [NDIV+1];
    logic signed [W-1:0] dv_p_reg   [NDIV+1][4];
    logic [W:0]          dv_d_reg   [NDIV+1][4];
    logic [W:0]          dv_rem_reg [NDIV+1][4];
    logic [PW-1:0]       dv_z_reg   [NDIV+1][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_inside_reg[0] <= c_inside_reg;
            dv_reject_reg[0] <= c_reject_reg;
            dv_neg_reg[0]    <= c_neg_reg;
            dv_p_reg[0]      <= c_p_reg;
            dv_d_reg[0]      <= c_md_reg;
            for (int u = 0; u < 4; u++)
            begin
                dv_rem_reg[0][u] <= '0;
                dv_z_reg[0][u]   <= PW'(c_pl_reg[u]) + (PW'(c_ph_reg[u]) << LH);
            end
        end
    end

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        logic [W:0]    rem_next [4];
        logic [PW-1:0] z_next   [4];

        // Restoring division steps: remainder in rem, dividend out / quotient in via z
        always_comb
        begin
            logic [W:0]    rem;
            logic [PW-1:0] z;
            logic [W+1:0]  t;
            logic          qb;

            for (int u = 0; u < 4; u++)
            begin
                rem = dv_rem_reg[k][u];
                z   = dv_z_reg[k][u];
                for (int s = 0; s < STEPS; s++)
                begin
                    t  = {rem, z[PW-1]};
                    qb = (t >= {1'b0, dv_d_reg[k][u]});
                    if (qb)
                        rem = (W+1)'(t - {1'b0, dv_d_reg[k][u]});
                    else
                        rem = t[W:0];
                    z = {z[PW-2:0], qb};
                end
                rem_next[u] = rem;
                z_next[u]   = z;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_inside_reg[k+1] <= dv_inside_reg[k];
                dv_reject_reg[k+1] <= dv_reject_reg[k];
                dv_neg_reg[k+1]    <= dv_neg_reg[k];
                dv_p_reg[k+1]      <= dv_p_reg[k];
                dv_d_reg[k+1]      <= dv_d_reg[k];
                dv_rem_reg[k+1]    <= rem_next;
                dv_z_reg[k+1]      <= z_next;
            end
        end
    end

    // Stage E: signed cut values (horizontal cuts unclamped, vertical cuts wrapped)
    logic                e_valid_reg;
    logic signed [W-1:0] e_p_reg [4];
    logic                e_inside_reg, e_reject_reg;
    logic signed [63:0]  e_xh_reg [2];
    logic signed [W-1:0] e_yv_reg [2];

    logic signed [63:0]  e_xh_next [2];
    logic signed [W-1:0] e_yv_next [2];

    always_comb
    begin
        logic signed [W-1:0] p [4];
        logic [PW+RW-1:0]    qx;
        logic [RW-1:0]       r;
        logic [63:0]         sr64;
        logic [W-1:0]        srw;
        logic signed [W:0]   sx, sy;
        logic [W:0]          mx, my;
        logic signed [W-1:0] midx, midy;

        p  = dv_p_reg[NDIV];
        // Midpoints truncate toward zero: bias odd negative sums up by one
        sx = (W+1)'(p[0]) + (W+1)'(p[2]);
        sy = (W+1)'(p[1]) + (W+1)'(p[3]);
        mx = sx + (W+1)'(sx[W] & sx[0]);
        my = sy + (W+1)'(sy[W] & sy[0]);
        midx = mx[W:1];
        midy = my[W:1];

        for (int h = 0; h < 2; h++)
        begin
            qx   = (PW+RW)'(dv_z_reg[NDIV][h]);
            r    = qx[RW-1:0];
            sr64 = dv_neg_reg[NDIV][h] ? -(64'(r)) : 64'(r);
            if (p[1] == p[3])
                e_xh_next[h] = 64'(midx);
            else
                e_xh_next[h] = 64'(p[0]) + sr64;
        end
        for (int v = 0; v < 2; v++)
        begin
            qx  = (PW+RW)'(dv_z_reg[NDIV][v+2]);
            srw = dv_neg_reg[NDIV][v+2] ? -qx[W-1:0] : qx[W-1:0];
            if (p[0] == p[2])
                e_yv_next[v] = midy;
            else
                e_yv_next[v] = p[1] + srw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (adv)
            e_valid_reg <= dv_valid_reg[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_p_reg      <= dv_p_reg[NDIV];
            e_inside_reg <= dv_inside_reg[NDIV];
            e_reject_reg <= dv_reject_reg[NDIV];
            e_xh_reg     <= e_xh_next;
            e_yv_reg     <= e_yv_next;
        end
    end

    // Stage F: pin horizontal cuts to the x span, chop against top and bottom
    logic                f_valid_reg;
    logic signed [W-1:0] f_p_reg [4];
    logic                f_inside_reg, f_reject_reg;
    logic signed [W-1:0] f_tx_reg [2];
    logic signed [W-1:0] f_ty_reg [2];
    logic signed [W-1:0] f_yv_reg [2];

    logic signed [W-1:0] f_tx_next [2];
    logic signed [W-1:0] f_ty_next [2];

    always_comb
    begin
        logic signed [W-1:0] lo, hi;
        logic signed [W-1:0] xc [2];
        logic                lo_end, hi_end;

        lo = (e_p_reg[0] < e_p_reg[2]) ? e_p_reg[0] : e_p_reg[2];
        hi = (e_p_reg[0] < e_p_reg[2]) ? e_p_reg[2] : e_p_reg[0];
        for (int h = 0; h < 2; h++)
        begin
            priority if (e_xh_reg[h] < 64'(lo))
                xc[h] = lo;
            else if (e_xh_reg[h] > 64'(hi))
                xc[h] = hi;
            else
                xc[h] = e_xh_reg[h][W-1:0];
        end

        f_tx_next[0] = e_p_reg[0];
        f_ty_next[0] = e_p_reg[1];
        f_tx_next[1] = e_p_reg[2];
        f_ty_next[1] = e_p_reg[3];
        // Equal y: the second endpoint counts as the lower one
        lo_end = !(e_p_reg[1] < e_p_reg[3]);
        hi_end = !lo_end;
        if (f_ty_next[lo_end] < min_y_reg)
        begin
            f_tx_next[lo_end] = xc[0];
            f_ty_next[lo_end] = min_y_reg;
        end
        if (f_ty_next[hi_end] > max_y_reg)
        begin
            f_tx_next[hi_end] = xc[1];
            f_ty_next[hi_end] = max_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= e_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_p_reg      <= e_p_reg;
            f_inside_reg <= e_inside_reg;
            f_reject_reg <= e_reject_reg;
            f_tx_reg     <= f_tx_next;
            f_ty_reg     <= f_ty_next;
            f_yv_reg     <= e_yv_reg;
        end
    end

    // Stage G: second x check, chop against left and right, form the result
    logic                o_visible_reg;
    logic signed [W-1:0] o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;

    logic                o_visible_next;
    logic signed [W-1:0] o_sx_next, o_sy_next, o_ex_next, o_ey_next;

    always_comb
    begin
        logic signed [W-1:0] tx [2];
        logic signed [W-1:0] ty [2];
        logic                l_end, r_end;
        logic                x_reject;

        tx    = f_tx_reg;
        ty    = f_ty_reg;
        l_end = !(tx[0] < tx[1]);
        r_end = !l_end;
        x_reject = ((tx[r_end] <= min_x_reg) || (tx[l_end] >= max_x_reg)) &&
                   (tx[l_end] < tx[r_end]);
        if (tx[l_end] < min_x_reg)
        begin
            ty[l_end] = f_yv_reg[0];
            tx[l_end] = min_x_reg;
        end
        if (tx[r_end] > max_x_reg)
        begin
            ty[r_end] = f_yv_reg[1];
            tx[r_end] = max_x_reg;
        end

        priority if (f_inside_reg)
        begin
            o_visible_next = 1'b1;
            o_sx_next = f_p_reg[0];
            o_sy_next = f_p_reg[1];
            o_ex_next = f_p_reg[2];
            o_ey_next = f_p_reg[3];
        end
        else if (f_reject_reg || x_reject)
        begin
            o_visible_next = 1'b0;
            o_sx_next = f_p_reg[0];
            o_sy_next = f_p_reg[1];
            o_ex_next = f_p_reg[2];
            o_ey_next = f_p_reg[3];
        end
        else
        begin
            o_visible_next = 1'b1;
            o_sx_next = tx[0];
            o_sy_next = ty[0];
            o_ex_next = tx[1];
            o_ey_next = ty[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_visible_reg <= o_visible_next;
            o_sx_reg      <= o_sx_next;
            o_sy_reg      <= o_sy_next;
            o_ex_reg      <= o_ex_next;
            o_ey_reg      <= o_ey_next;
        end
    end

    assign res.valid        = o_valid_reg;
    assign res.visible      = o_visible_reg;
    assign res.clip_start_x = o_sx_reg;
    assign res.clip_start_y = o_sy_reg;
    assign res.clip_end_x   = o_ex_reg;
    assign res.clip_end_y   = o_ey_reg;

endmodule

`default_nettype wire
